### rtl/sdt_pkg.sv
`default_nettype none
package sdt_pkg;

    localparam int DEF_TABLE_SLOTS = 128;
    localparam int DEF_MAX_ARGS    = 16;
    localparam int STAGE_WORDS     = 31;
    localparam int SCAN_STEP       = 8;

    localparam logic [15:0] HDR_PAY_MASK = 16'hFFE0;
    localparam logic [15:0] HDR_CNT_MASK = 16'h001F;

    localparam int HDR_W  = 16;
    localparam int TAIL_W = 13;
    localparam int WRAP_W = 16;
    localparam int META_W = HDR_W + TAIL_W + WRAP_W;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_REJ  = 2'd2;

    localparam logic REG_ARGS  = 1'b0;
    localparam logic REG_SLOTS = 1'b1;

    localparam logic KIND_PUT = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_PUT_RD,
        ST_PUT_WR,
        ST_Q_HDR,
        ST_Q_META,
        ST_Q_CMP,
        ST_MATCH,
        ST_SCAN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [HDR_W-1:0]  hdr;
        logic [TAIL_W-1:0] tail;
        logic [WRAP_W-1:0] wrap;
    } t_meta;

endpackage
`default_nettype wire

### rtl/signature_dispatch_table_unit.sv
// Put run: after the run end, dispatch, a metadata read, writes of all 2*MAX_ARGS-1 type words, next-free scan.
// Query run: dispatch, then per visited slot a header check, word compares, a hit update if it matches.
// Next-free scan: checks 8 slots (SCAN_STEP) at a time up to the configured slot count.
// One request at a time; the next request is taken once the result is in the output register.
// Reset (synchronous, active low) clears control, config and the slot occupancy bits;
// memory contents are qualified by those bits, so no clearing pass is needed.
`default_nettype none
module signature_dispatch_table_unit
    import sdt_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int MAX_ARGS    = DEF_MAX_ARGS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_slot_index,
    input  wire logic [15:0] i_type_word,
    input  wire logic [4:0]  i_word_count,
    input  wire logic [15:0] i_payload,
    input  wire logic        i_last_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_found_payload,
    output logic [7:0]       o_matched_slot,
    output logic [7:0]       o_hit_count,
    output logic [15:0]      o_wrap_count,
    output logic [7:0]       o_next_free,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SLOT_WORDS = 2 * MAX_ARGS - 1;
    localparam int TW_DEPTH   = TABLE_SLOTS * SLOT_WORDS;
    localparam int TAW        = (TW_DEPTH > 1) ? $clog2(TW_DEPTH) : 1;
    localparam int SIW        = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int SW         = $clog2(TABLE_SLOTS + 1);
    localparam int SCW        = $clog2(TABLE_SLOTS + SCAN_STEP + 1);

    t_state r_state, n_state;

    logic [4:0]  r_args;
    logic [7:0]  r_slots;

    logic [15:0] r_stage [STAGE_WORDS];
    logic [4:0]  r_pos;
    logic        r_kind;
    logic [7:0]  r_rslot;
    logic [4:0]  r_len;
    logic [15:0] r_pay;

    logic [TABLE_SLOTS-1:0] r_occ;
    logic [TABLE_SLOTS-1:0] r_mv;

    logic [SW-1:0] r_s, n_s;
    logic [4:0]    r_w, n_w;
    t_meta         r_meta, n_meta;

    logic [1:0]  r_st, n_st;
    logic [15:0] r_fp, n_fp;
    logic [7:0]  r_ms, n_ms;
    logic [7:0]  r_hc, n_hc;
    logic [15:0] r_wc, n_wc;
    logic [7:0]  r_nf, n_nf;

    logic        r_ovalid;

    logic           meta_we, meta_re;
    logic [SIW-1:0] meta_addr;
    t_meta          meta_wdata, meta_rdata;
    logic           tw_we, tw_re;
    logic [TAW-1:0] tw_addr;
    logic [15:0]    tw_wdata, tw_rdata;

    logic [4:0]    eff_args;
    logic [SW-1:0] eff_slots;
    logic [5:0]    cap;
    logic          in_acc;
    logic          occ_set, occ_val, mv_set;
    logic [TABLE_SLOTS+SCAN_STEP-1:0] occ_pad;
    logic [7:0]    hc_next;
    logic [15:0]   wrap_next, match_v;
    logic          scan_found;
    logic [SCW-1:0] scan_idx, scan_hit;

    sdt_ram #(.WIDTH(META_W), .DEPTH(TABLE_SLOTS), .AW(SIW)) u_meta (
        .i_clk  (i_clk),
        .i_we   (meta_we),
        .i_waddr(meta_addr),
        .i_wdata(meta_wdata),
        .i_re   (meta_re),
        .i_raddr(meta_addr),
        .o_rdata(meta_rdata)
    );

    sdt_ram #(.WIDTH(16), .DEPTH(TW_DEPTH), .AW(TAW)) u_words (
        .i_clk  (i_clk),
        .i_we   (tw_we),
        .i_waddr(tw_addr),
        .i_wdata(tw_wdata),
        .i_re   (tw_re),
        .i_raddr(tw_addr),
        .o_rdata(tw_rdata)
    );

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            REG_ARGS:  prdata = {27'd0, r_args};
            REG_SLOTS: prdata = {24'd0, r_slots};
            default:   prdata = 32'd0;
        endcase
    end

    always_comb begin
        eff_args = r_args;
        if (r_args == 5'd0) eff_args = 5'd1;
        else if (32'(r_args) > MAX_ARGS) eff_args = 5'(MAX_ARGS);
        cap = {eff_args, 1'b0} - 6'd1;
        eff_slots = SW'(r_slots);
        if (r_slots == 8'd0) eff_slots = SW'(1);
        else if (32'(r_slots) > TABLE_SLOTS) eff_slots = SW'(TABLE_SLOTS);
    end

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign occ_pad = {{SCAN_STEP{1'b1}}, r_occ};

    assign hc_next   = r_meta.tail[12:5] + 8'd1;
    assign wrap_next = (hc_next == 8'd0) ? r_meta.wrap + 16'd1 : r_meta.wrap;
    assign match_v   = (r_meta.hdr & HDR_PAY_MASK) | {11'd0, r_meta.tail[4:0]};

    always_comb begin
        scan_found = 1'b0;
        scan_hit   = '0;
        scan_idx   = '0;
        for (int j = 0; j < SCAN_STEP; j++) begin
            scan_idx = SCW'(r_s) + SCW'(j);
            if (!scan_found && (scan_idx < SCW'(eff_slots)) && !occ_pad[scan_idx]) begin
                scan_found = 1'b1;
                scan_hit   = scan_idx;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_s        = r_s;
        n_w        = r_w;
        n_meta     = r_meta;
        n_st       = r_st;
        n_fp       = r_fp;
        n_ms       = r_ms;
        n_hc       = r_hc;
        n_wc       = r_wc;
        n_nf       = r_nf;
        meta_we    = 1'b0;
        meta_re    = 1'b0;
        meta_addr  = r_s[SIW-1:0];
        meta_wdata = r_meta;
        tw_we      = 1'b0;
        tw_re      = 1'b0;
        tw_addr    = TAW'(32'(r_s) * SLOT_WORDS + 32'(r_w));
        tw_wdata   = (r_w < r_len) ? r_stage[r_w] : 16'd0;
        occ_set    = 1'b0;
        occ_val    = 1'b0;
        mv_set     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_last_word) n_state = ST_DISP;
            end
            ST_DISP: begin
                n_fp = '0;
                n_ms = '0;
                n_hc = '0;
                n_wc = '0;
                n_w  = '0;
                if ({1'b0, r_len} > cap) begin
                    n_st    = STAT_REJ;
                    n_s     = '0;
                    n_state = ST_SCAN;
                end else if (r_kind == KIND_PUT) begin
                    if (r_rslot == 8'd0 || 32'(r_rslot) > 32'(eff_slots)) begin
                        n_st    = STAT_REJ;
                        n_s     = '0;
                        n_state = ST_SCAN;
                    end else begin
                        n_st    = STAT_OK;
                        n_s     = SW'(r_rslot - 8'd1);
                        n_state = ST_PUT_RD;
                    end
                end else begin
                    n_st    = STAT_MISS;
                    n_s     = '0;
                    n_state = ST_Q_HDR;
                end
            end
            ST_PUT_RD: begin
                meta_re = 1'b1;
                n_state = ST_PUT_WR;
            end
            ST_PUT_WR: begin
                tw_we = 1'b1;
                if (r_w == 5'd0) begin
                    meta_we         = 1'b1;
                    meta_wdata.hdr  = (r_pay & HDR_PAY_MASK) | {11'd0, r_len};
                    meta_wdata.tail = {8'd0, r_pay[4:0]};
                    meta_wdata.wrap = r_mv[r_s[SIW-1:0]] ? meta_rdata.wrap : 16'd0;
                    occ_set         = 1'b1;
                    occ_val         = (meta_wdata.hdr != 16'd0);
                    mv_set          = 1'b1;
                end
                if (32'(r_w) == SLOT_WORDS - 1) begin
                    n_s     = '0;
                    n_state = ST_SCAN;
                end else begin
                    n_w = r_w + 5'd1;
                end
            end
            ST_Q_HDR: begin
                if (r_s >= eff_slots || !r_occ[r_s[SIW-1:0]]) begin
                    n_s     = '0;
                    n_state = ST_SCAN;
                end else begin
                    meta_re = 1'b1;
                    n_state = ST_Q_META;
                end
            end
            ST_Q_META: begin
                n_meta = meta_rdata;
                n_w    = '0;
                if ((meta_rdata.hdr & HDR_CNT_MASK) != {11'd0, r_len}) begin
                    n_s     = r_s + SW'(1);
                    n_state = ST_Q_HDR;
                end else if (r_len == 5'd0) begin
                    n_state = ST_MATCH;
                end else begin
                    tw_re   = 1'b1;
                    tw_addr = TAW'(32'(r_s) * SLOT_WORDS);
                    n_state = ST_Q_CMP;
                end
            end
            ST_Q_CMP: begin
                if (tw_rdata != r_stage[r_w]) begin
                    n_s     = r_s + SW'(1);
                    n_state = ST_Q_HDR;
                end else if (r_w + 5'd1 == r_len) begin
                    n_state = ST_MATCH;
                end else begin
                    n_w     = r_w + 5'd1;
                    tw_re   = 1'b1;
                    tw_addr = TAW'(32'(r_s) * SLOT_WORDS + 32'(r_w) + 1);
                end
            end
            ST_MATCH: begin
                meta_we         = 1'b1;
                meta_wdata.tail = {hc_next, r_meta.tail[4:0]};
                meta_wdata.wrap = wrap_next;
                if (match_v != 16'd0) begin
                    n_st    = STAT_OK;
                    n_fp    = match_v;
                    n_ms    = 8'(r_s) + 8'd1;
                    n_hc    = hc_next;
                    n_wc    = wrap_next;
                    n_s     = '0;
                    n_state = ST_SCAN;
                end else begin
                    n_s     = r_s + SW'(1);
                    n_state = ST_Q_HDR;
                end
            end
            ST_SCAN: begin
                if (scan_found) begin
                    n_nf    = 8'(scan_hit) + 8'd1;
                    n_state = ST_OUT;
                end else if (SCW'(r_s) + SCW'(SCAN_STEP) >= SCW'(eff_slots)) begin
                    n_nf    = 8'd0;
                    n_state = ST_OUT;
                end else begin
                    n_s = r_s + SW'(SCAN_STEP);
                end
            end
            ST_OUT: begin
                if (!r_ovalid || !i_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_args   <= 5'(DEF_MAX_ARGS);
            r_slots  <= 8'(DEF_TABLE_SLOTS);
            r_pos    <= '0;
            r_occ    <= '0;
            r_mv     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && pready) begin
                unique case (paddr[2])
                    REG_ARGS:  r_args  <= pwdata[4:0];
                    REG_SLOTS: r_slots <= pwdata[7:0];
                    default:   r_args  <= r_args;
                endcase
            end
            if (in_acc) begin
                r_pos <= i_last_word ? 5'd0 :
                         (r_pos < 5'(STAGE_WORDS)) ? r_pos + 5'd1 : r_pos;
            end
            if (occ_set) r_occ[r_s[SIW-1:0]] <= occ_val;
            if (mv_set) r_mv[r_s[SIW-1:0]] <= 1'b1;
            if (r_state == ST_OUT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (r_pos < 5'(STAGE_WORDS)) r_stage[r_pos] <= i_type_word;
            if (r_pos == 5'd0) begin
                r_kind  <= i_kind;
                r_rslot <= i_slot_index;
                r_len   <= i_word_count;
                r_pay   <= i_payload;
            end
        end
        r_s    <= n_s;
        r_w    <= n_w;
        r_meta <= n_meta;
        r_st   <= n_st;
        r_fp   <= n_fp;
        r_ms   <= n_ms;
        r_hc   <= n_hc;
        r_wc   <= n_wc;
        r_nf   <= n_nf;
        if (r_state == ST_OUT && (!r_ovalid || !i_stall)) begin
            o_status        <= r_st;
            o_found_payload <= r_fp;
            o_matched_slot  <= r_ms;
            o_hit_count     <= r_hc;
            o_wrap_count    <= r_wc;
            o_next_free     <= r_nf;
        end
    end

    assign o_valid = r_ovalid;

endmodule
`default_nettype wire

### rtl/sdt_ram.sv
`default_nettype none
module sdt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire
